// ----- src/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, widths and control types for the least-squares slope block
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int MAX_POINTS = 255;
  localparam int COORD_BITS = 8;
  localparam int FIELD_W    = 8;
  localparam int FRAC_BITS  = 16;
  localparam int SLOPE_W    = 32;

  localparam int COORD_USE  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = COORD_BITS + CNT_W;
  localparam int SQ_W       = 2 * COORD_BITS + CNT_W;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int MUL_STEPS  = 4;
  localparam int DIV_STEPS  = PROD_W + FRAC_BITS;
  localparam int QX_W       = (DIV_STEPS > SLOPE_W + 1) ? DIV_STEPS : SLOPE_W + 1;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [QX_W-1:0] Q_POS_MAX = QX_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
  localparam logic [QX_W-1:0] Q_NEG_MAX = QX_W'(64'd1 << (SLOPE_W - 1));
  localparam logic [SLOPE_W-1:0] SLOPE_POS_SAT = {1'b0, {(SLOPE_W - 1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_NEG_SAT = {1'b1, {(SLOPE_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    MUL_N_SXY,
    MUL_SX_SY,
    MUL_N_SXX,
    MUL_SX_SX
  } mul_sel_t;

  typedef struct packed {
    logic     acc_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sub_en;
    logic     div_init;
    logic     div_step;
    logic     load_out;
  } lss_cmd_t;

  typedef struct packed {
    logic den_zero;
  } lss_sts_t;

endpackage

// ----- src/lss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: accumulate phase, product steps, divide iterations, result hand-off
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  lss_sts_t sts,
  output lss_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL,
    ST_SUB,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic              out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_ACCUM);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_ACCUM: begin
          if (in_tvalid && in_tlast) begin
            state_r <= ST_MUL;
            step_r  <= '0;
          end
        end
        ST_MUL: begin
          if (step_r == STEP_W'(MUL_STEPS - 1)) begin
            state_r <= ST_SUB;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_SUB: begin
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          step_r <= '0;
          if (sts.den_zero) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_ACCUM;
          end
        end
        default: begin
          state_r <= ST_ACCUM;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = mul_sel_t'(step_r[1:0]);
    cmd.acc_en   = (state_r == ST_ACCUM) && in_tvalid;
    cmd.mul_en   = (state_r == ST_MUL);
    cmd.sub_en   = (state_r == ST_SUB);
    cmd.div_init = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.load_out = (state_r == ST_FIN) && out_free;
  end

endmodule

// ----- src/lss_dp.sv -----
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: running sums, shared product unit, restoring divider, output register
// ----------------------------------------------------------------------------
module lss_dp
  import lss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lss_cmd_t           cmd,
  output lss_sts_t           sts,
  input  logic [FIELD_W-1:0] point_x,
  input  logic [FIELD_W-1:0] point_y,
  output logic [SLOPE_W-1:0] slope_q16,
  output logic               vertical,
  output logic [FIELD_W-1:0] points_used,
  output logic               dropped
);

  logic [COORD_BITS-1:0]   x_c;
  logic [COORD_BITS-1:0]   y_c;
  logic [2*COORD_BITS-1:0] xx;
  logic [2*COORD_BITS-1:0] xy;

  logic [CNT_W-1:0] count_r;
  logic [SUM_W-1:0] sx_r;
  logic [SUM_W-1:0] sy_r;
  logic [SQ_W-1:0]  sxx_r;
  logic [SQ_W-1:0]  sxy_r;
  logic             drop_r;

  logic [SUM_W-1:0]      mul_a;
  logic [SQ_W-1:0]       mul_b;
  logic [SUM_W+SQ_W-1:0] mul_full;
  logic [PROD_W-1:0]     term_r [MUL_STEPS];

  logic signed [PROD_W:0] num_r;
  logic signed [PROD_W:0] den_r;
  logic        [PROD_W:0] num_mag;

  logic [PROD_W-1:0]    rem_r;
  logic [PROD_W-1:0]    div_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic                 neg_r;
  logic [PROD_W:0]      rem_shl;
  logic [PROD_W+1:0]    trial;
  logic                 fits;

  logic [QX_W-1:0]    q_ext;
  logic [SLOPE_W-1:0] slope_sat;

  logic [SLOPE_W-1:0] slope_r;
  logic               vert_r;
  logic [CNT_W-1:0]   used_r;
  logic               dropped_r;

  assign x_c = COORD_BITS'(point_x[COORD_USE-1:0]);
  assign y_c = COORD_BITS'(point_y[COORD_USE-1:0]);
  assign xx  = x_c * x_c;
  assign xy  = x_c * y_c;

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count_r < CNT_W'(MAX_POINTS)) begin
        count_r <= count_r + 1'b1;
        sx_r    <= sx_r + SUM_W'(x_c);
        sy_r    <= sy_r + SUM_W'(y_c);
        sxx_r   <= sxx_r + SQ_W'(xx);
        sxy_r   <= sxy_r + SQ_W'(xy);
      end else begin
        drop_r <= 1'b1;
      end
    end else if (cmd.load_out) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      drop_r  <= 1'b0;
    end
  end

  // one shared multiplier, one product per step
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_N_SXY: begin
        mul_a = SUM_W'(count_r);
        mul_b = sxy_r;
      end
      MUL_SX_SY: begin
        mul_a = sx_r;
        mul_b = SQ_W'(sy_r);
      end
      MUL_N_SXX: begin
        mul_a = SUM_W'(count_r);
        mul_b = sxx_r;
      end
      MUL_SX_SX: begin
        mul_a = sx_r;
        mul_b = SQ_W'(sx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      term_r[cmd.mul_sel] <= PROD_W'(mul_full);
    end
  end

  // numerator and denominator
  always_ff @(posedge clk) begin
    if (cmd.sub_en) begin
      num_r <= $signed({1'b0, term_r[MUL_N_SXY]}) - $signed({1'b0, term_r[MUL_SX_SY]});
      den_r <= $signed({1'b0, term_r[MUL_N_SXX]}) - $signed({1'b0, term_r[MUL_SX_SX]});
    end
  end

  assign sts.den_zero = den_r[PROD_W] || (den_r == '0);
  assign num_mag      = num_r[PROD_W] ? (PROD_W + 1)'(-num_r) : num_r;

  // restoring divider, one quotient bit per cycle
  assign rem_shl = {rem_r, quo_r[DIV_STEPS-1]};
  assign trial   = {1'b0, rem_shl} - {2'b00, div_r};
  assign fits    = !trial[PROD_W+1];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      div_r <= den_r[PROD_W-1:0];
      quo_r <= {num_mag[PROD_W-1:0], FRAC_BITS'(0)};
      neg_r <= num_r[PROD_W];
    end else if (cmd.div_step) begin
      rem_r <= fits ? trial[PROD_W-1:0] : rem_shl[PROD_W-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], fits};
    end
  end

  // saturate to signed slope
  assign q_ext = QX_W'(quo_r);

  always_comb begin
    if (neg_r) begin
      if (q_ext > Q_NEG_MAX) begin
        slope_sat = SLOPE_NEG_SAT;
      end else begin
        slope_sat = SLOPE_W'(QX_W'(0) - q_ext);
      end
    end else begin
      if (q_ext > Q_POS_MAX) begin
        slope_sat = SLOPE_POS_SAT;
      end else begin
        slope_sat = SLOPE_W'(q_ext);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slope_r   <= sts.den_zero ? '0 : slope_sat;
      vert_r    <= sts.den_zero;
      used_r    <= count_r;
      dropped_r <= drop_r;
    end
  end

  assign slope_q16   = slope_r;
  assign vertical    = vert_r;
  assign points_used = FIELD_W'(used_r);
  assign dropped     = dropped_r;

endmodule

// ----- src/least_squares_slope_top.sv -----
// ----------------------------------------------------------------------------
// least_squares_slope_top
// Least-squares line fit over a stream of image points, slope in Q15.16
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the set is being gathered; each adds
// to the count and to the sums of x, y, x*x and x*y. The item flagged with
// in_tlast closes the set: the block then stops taking items for the product,
// difference and result loading work (one shared multiplier, four products)
// and for the one-bit-per-cycle restoring divider, which is skipped when the
// denominator is zero; it also stays stalled while an earlier result
// still waits in the output register. The result sits in an output register,
// so the next set can start gathering while it waits to be taken. Points past
// the count limit are dropped and reported; a zero denominator gives slope 0
// and the vertical flag.
module least_squares_slope_top
  import lss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // point_x, point_y
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // slope_q16, points_used
  output logic [1:0]  out_tuser   // vertical, dropped
);

  lss_cmd_t           cmd;
  lss_sts_t           sts;
  logic [SLOPE_W-1:0] slope_q16;
  logic               vertical;
  logic [FIELD_W-1:0] points_used;
  logic               dropped;

  lss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .point_x     (in_tdata[7:0]),
    .point_y     (in_tdata[15:8]),
    .slope_q16   (slope_q16),
    .vertical    (vertical),
    .points_used (points_used),
    .dropped     (dropped)
  );

  assign out_tdata = {points_used, slope_q16};
  assign out_tuser = {dropped, vertical};

endmodule

// ----- tb/least_squares_slope_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_squares_slope_top_tb
// Self-checking bench for the least-squares slope block
// ----------------------------------------------------------------------------
// Point sets are queued up front and streamed in by a clocked driver with
// random gaps. Every accepted point updates a local line-fit model, and each
// point that closes a set yields the expected slope, flags and count. A
// clocked monitor takes results under random back-pressure, including one
// long hold-off that fills the block, and compares them field by field.
// ----------------------------------------------------------------------------
module least_squares_slope_top_tb;
  import lss_pkg::*;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
  } point_t;

  typedef struct {
    logic [31:0] slope;
    logic        vertical;
    logic [7:0]  used;
    logic        dropped;
  } fit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  point_t point_queue[$];
  fit_t   slope_due[$];

  // running sums of the open set
  logic [CNT_W-1:0] set_count = '0;
  logic [SUM_W-1:0] set_sx = '0;
  logic [SUM_W-1:0] set_sy = '0;
  logic [SQ_W-1:0]  set_sxx = '0;
  logic [SQ_W-1:0]  set_sxy = '0;
  logic             set_dropped = 1'b0;

  logic in_took = 1'b0;
  logic hold_off = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   mismatches = 0;
  int   results_seen = 0;

  least_squares_slope_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // accumulate one point and close the fit when it ends the set
  task automatic fit_point(input logic [7:0] px, input logic [7:0] py, input logic lst);
    longint cx, cy, n, sx, sy, sxx, sxy, num, den, q;
    fit_t   f;
    cx = longint'(px) & ((64'd1 << COORD_BITS) - 1);
    cy = longint'(py) & ((64'd1 << COORD_BITS) - 1);
    if (set_count < MAX_POINTS) begin
      set_count = set_count + 1'b1;
      set_sx    = set_sx + SUM_W'(cx);
      set_sy    = set_sy + SUM_W'(cy);
      set_sxx   = set_sxx + SQ_W'(cx * cx);
      set_sxy   = set_sxy + SQ_W'(cx * cy);
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      n   = longint'(set_count);
      sx  = longint'(set_sx);
      sy  = longint'(set_sy);
      sxx = longint'(set_sxx);
      sxy = longint'(set_sxy);
      num = n * sxy - sx * sy;
      den = n * sxx - sx * sx;
      if (den <= 0) begin
        f.slope    = '0;
        f.vertical = 1'b1;
      end else begin
        q = (num * 65536) / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        f.slope    = q[31:0];
        f.vertical = 1'b0;
      end
      f.used    = 8'(set_count);
      f.dropped = set_dropped;
      slope_due.push_back(f);
      set_count   = '0;
      set_sx      = '0;
      set_sy      = '0;
      set_sxx     = '0;
      set_sxy     = '0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic push_point(input logic [7:0] px, input logic [7:0] py, input logic lst);
    point_t p;
    p.x    = px;
    p.y    = py;
    p.last = lst;
    point_queue.push_back(p);
  endtask

  task automatic push_set(input int len);
    for (int i = 0; i < len; i++)
      push_point(8'($urandom), 8'($urandom), i == len - 1);
  endtask

  // input side: accepted items feed the model
  always @(posedge clk) begin
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took)
      fit_point(in_tdata[7:0], in_tdata[15:8], in_tlast);
  end

  // point driver
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (point_queue.size() != 0) begin
        p = point_queue.pop_front();
        in_tdata  <= {p.y, p.x};
        in_tlast  <= p.last;
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) out_gap = pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (slope_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: slope %h used %0d tuser %b",
                   out_tdata[31:0], out_tdata[39:32], out_tuser);
        mismatches++;
      end else begin
        e = slope_due.pop_front();
        if (out_tdata[31:0] !== e.slope || out_tuser[0] !== e.vertical ||
            out_tdata[39:32] !== e.used || out_tuser[1] !== e.dropped) begin
          if (mismatches < 10)
            $display("mismatch: slope %h/%h vertical %b/%b used %0d/%0d dropped %b/%b",
                     e.slope, out_tdata[31:0], e.vertical, out_tuser[0],
                     e.used, out_tdata[39:32], e.dropped, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (results_seen >= 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int rand_items;
    int len;

    // single points and shared x
    push_point(8'd255, 8'd255, 1'b1);
    push_point(8'd0, 8'd0, 1'b1);
    push_point(8'd7, 8'd0, 1'b0);
    push_point(8'd7, 8'd255, 1'b0);
    push_point(8'd7, 8'd100, 1'b1);
    // rising, falling and steep lines
    push_point(8'd0, 8'd0, 1'b0);
    push_point(8'd255, 8'd255, 1'b1);
    push_point(8'd0, 8'd255, 1'b0);
    push_point(8'd255, 8'd0, 1'b1);
    push_point(8'd0, 8'd0, 1'b0);
    push_point(8'd1, 8'd255, 1'b1);
    push_point(8'd255, 8'd0, 1'b0);
    push_point(8'd254, 8'd255, 1'b0);
    push_point(8'd0, 8'd128, 1'b1);
    push_point(8'd170, 8'd85, 1'b0);
    push_point(8'd85, 8'd170, 1'b0);
    push_point(8'd3, 8'd12, 1'b0);
    push_point(8'd200, 8'd7, 1'b1);
    // full count, last point dropped, many dropped
    push_set(MAX_POINTS);
    push_set(MAX_POINTS + 1);
    push_set(MAX_POINTS + 15);

    rand_items = 0;
    while (rand_items < 400) begin
      if ($urandom_range(0, 99) < 3)
        len = $urandom_range(240, 270);
      else if ($urandom_range(0, 9) == 0)
        len = $urandom_range(1, 2);
      else
        len = $urandom_range(3, 24);
      if ($urandom_range(0, 9) == 0) begin
        // shared x with random rows
        for (int i = 0; i < len; i++)
          push_point(8'(len * 37), 8'($urandom), i == len - 1);
      end else begin
        push_set(len);
      end
      rand_items += len;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (point_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (slope_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- least_squares_slope_top.f -----
src/lss_pkg.sv
src/lss_ctrl.sv
src/lss_dp.sv
src/least_squares_slope_top.sv
tb/least_squares_slope_top_tb.sv
